>>> src/bsr_pkg.sv
// Shared types and constants for the bridge converter serial reader.
// No dependencies; imported by every module of the block.
package bsr_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int RAW_W       = 24;
    localparam int SCALED_W    = 40;
    localparam int TICK_W      = 20;

    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_READY_TIMEOUT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PULSES_A      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PULSES_B      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_A       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_B       = 3'd6;

    localparam logic [7:0]        RST_HALF_PERIOD   = 8'd1;
    localparam logic [TICK_W-1:0] RST_READY_TIMEOUT = 20'd100000;
    localparam logic [TICK_W-1:0] RST_SETTLE        = 20'd100000;
    localparam logic [1:0]        RST_PULSES_A      = 2'd2;
    localparam logic [1:0]        RST_PULSES_B      = 2'd3;
    localparam logic signed [31:0] RST_SCALE        = 32'sd65536;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_TIMEOUT = 1'b1;

    typedef struct packed {
        logic dout_level;
        logic start_req;
    } tick_t;

    typedef struct packed {
        logic sck_level;
        logic busy_res;
        logic done_res;
        logic status;
    } flags_t;

    typedef struct packed {
        logic                       sck_level;
        logic                       busy_res;
        logic                       done_res;
        logic                       status;
        logic signed [RAW_W-1:0]    raw_a;
        logic signed [RAW_W-1:0]    raw_b;
        logic signed [SCALED_W-1:0] scaled_a;
        logic signed [SCALED_W-1:0] scaled_b;
    } result_t;

endpackage

>>> src/bridge_adc_serial_reader.sv
// Top level of the bridge converter serial reader: configuration registers,
// sequencing state machine and first pipeline stage. Depends on bsr_pkg, bsr_scale.
//
// Usage:
//   tick channel   : one request per timing tick (data line level, start request).
//   result channel : exactly one result per tick, in tick order: clock line level,
//                    busy, done strobe, status and, on a good finish, both
//                    sign-extended readings and their Q16.16 scaled values.
//   cfg port       : write enable, register index, 32-bit data; write only when
//                    the block is idle and the result pipeline has drained.
// Throughput: one tick per cycle while result_ready stays high; the state
// machine step and the two 24x32 multipliers sit in separate register stages.
// Path: an accepted tick is registered in the stage register, then in the result
// register, from which the result handshake is taken.
// Reset: sequencer idle, clock line low, registers at their defaults, both
// pipeline stages empty.
// Stall: when the receiver holds result_ready low the result register holds,
// the stage register fills, then tick_ready drops until the receiver resumes.
module bridge_adc_serial_reader
    import bsr_pkg::*;
#(
    parameter int DATA_BITS = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   tick_valid,
    output logic                   tick_ready,
    input  tick_t                  tick,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int BitCntW = $clog2(DATA_BITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAIT,
        ST_HIGH,
        ST_LOW,
        ST_PULSE_HIGH,
        ST_PULSE_LOW,
        ST_SETTLE
    } phase_t;

    logic [7:0]          half_period_reg;
    logic [TICK_W-1:0]   timeout_reg;
    logic [TICK_W-1:0]   settle_reg;
    logic [1:0]          pulses_a_reg;
    logic [1:0]          pulses_b_reg;
    logic signed [31:0]  scale_a_reg;
    logic signed [31:0]  scale_b_reg;

    phase_t                phase_reg,   phase_next;
    logic [TICK_W-1:0]     tick_reg,    tick_next;
    logic [BitCntW-1:0]    bit_reg,     bit_next;
    logic [1:0]            pulse_reg,   pulse_next;
    logic [DATA_BITS-1:0]  shift_reg,   shift_next;
    logic                  second_reg,  second_next;
    logic [DATA_BITS-1:0]  held_reg,    held_next;
    logic                  sck_reg,     sck_next;

    logic                  stage_valid_reg;
    flags_t                stage_flags_reg;
    logic [DATA_BITS-1:0]  stage_a_reg;
    logic [DATA_BITS-1:0]  stage_b_reg;

    logic                  stage_ready;
    logic                  accept;
    logic                  done;
    logic                  timed_out;
    logic                  finish;
    logic [DATA_BITS-1:0]  reading_a;
    logic [DATA_BITS-1:0]  reading_b;
    logic [7:0]            half_period;
    logic [TICK_W:0]       tick_inc;
    logic                  half_done;
    logic [1:0]            target;
    logic [1:0]            pulse_inc;
    logic [BitCntW-1:0]    bit_inc;

    assign tick_ready = !stage_valid_reg || stage_ready;
    assign accept     = tick_valid && tick_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= RST_HALF_PERIOD;
            timeout_reg     <= RST_READY_TIMEOUT;
            settle_reg      <= RST_SETTLE;
            pulses_a_reg    <= RST_PULSES_A;
            pulses_b_reg    <= RST_PULSES_B;
            scale_a_reg     <= RST_SCALE;
            scale_b_reg     <= RST_SCALE;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_HALF_PERIOD:   half_period_reg <= cfg_data[7:0];
                CFG_READY_TIMEOUT: timeout_reg     <= cfg_data[TICK_W-1:0];
                CFG_SETTLE:        settle_reg      <= cfg_data[TICK_W-1:0];
                CFG_PULSES_A:      pulses_a_reg    <= cfg_data[1:0];
                CFG_PULSES_B:      pulses_b_reg    <= cfg_data[1:0];
                CFG_SCALE_A:       scale_a_reg     <= $signed(cfg_data);
                CFG_SCALE_B:       scale_b_reg     <= $signed(cfg_data);
                default:           ;
            endcase
        end
    end

    assign half_period = (half_period_reg == 8'd0) ? 8'd1 : half_period_reg;
    assign tick_inc    = {1'b0, tick_reg} + {{TICK_W{1'b0}}, 1'b1};
    assign half_done   = tick_inc >= {{(TICK_W-7){1'b0}}, half_period};
    assign target      = second_reg ? pulses_b_reg : pulses_a_reg;
    assign pulse_inc   = pulse_reg + 2'd1;
    assign bit_inc     = bit_reg + {{(BitCntW-1){1'b0}}, 1'b1};

    always_comb
    begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        bit_next    = bit_reg;
        pulse_next  = pulse_reg;
        shift_next  = shift_reg;
        second_next = second_reg;
        held_next   = held_reg;
        sck_next    = sck_reg;
        done        = 1'b0;
        timed_out   = 1'b0;
        finish      = 1'b0;
        reading_a   = '0;
        reading_b   = '0;

        case (phase_reg)
            ST_IDLE:
            begin
                if (tick.start_req)
                begin
                    phase_next  = ST_WAIT;
                    tick_next   = '0;
                    second_next = 1'b0;
                end
                sck_next = 1'b0;
            end
            ST_WAIT:
            begin
                if (!tick.dout_level)
                begin
                    phase_next = ST_HIGH;
                    tick_next  = '0;
                    bit_next   = '0;
                    shift_next = '0;
                    sck_next   = 1'b1;
                end
                else
                begin
                    tick_next = tick_inc[TICK_W-1:0];
                    if (tick_inc[TICK_W-1:0] >= timeout_reg)
                    begin
                        phase_next = ST_IDLE;
                        tick_next  = '0;
                        done       = 1'b1;
                        timed_out  = 1'b1;
                    end
                end
            end
            ST_HIGH:
            begin
                tick_next = tick_inc[TICK_W-1:0];
                if (half_done)
                begin
                    shift_next = {shift_reg[DATA_BITS-2:0], tick.dout_level};
                    tick_next  = '0;
                    sck_next   = 1'b0;
                    phase_next = ST_LOW;
                end
            end
            ST_LOW:
            begin
                tick_next = tick_inc[TICK_W-1:0];
                if (half_done)
                begin
                    tick_next = '0;
                    bit_next  = bit_inc;
                    if (bit_inc >= BitCntW'(DATA_BITS))
                    begin
                        pulse_next = '0;
                        if (target == 2'd0)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            phase_next = ST_PULSE_HIGH;
                            sck_next   = 1'b1;
                        end
                    end
                    else
                    begin
                        phase_next = ST_HIGH;
                        sck_next   = 1'b1;
                    end
                end
            end
            ST_PULSE_HIGH:
            begin
                tick_next = tick_inc[TICK_W-1:0];
                if (half_done)
                begin
                    tick_next  = '0;
                    sck_next   = 1'b0;
                    phase_next = ST_PULSE_LOW;
                end
            end
            ST_PULSE_LOW:
            begin
                tick_next = tick_inc[TICK_W-1:0];
                if (half_done)
                begin
                    tick_next  = '0;
                    pulse_next = pulse_inc;
                    if (pulse_inc >= target)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        phase_next = ST_PULSE_HIGH;
                        sck_next   = 1'b1;
                    end
                end
            end
            ST_SETTLE:
            begin
                tick_next = tick_inc[TICK_W-1:0];
                if (tick_inc >= {1'b0, settle_reg})
                begin
                    tick_next  = '0;
                    phase_next = ST_WAIT;
                end
            end
            default:
            begin
                phase_next = ST_IDLE;
                sck_next   = 1'b0;
            end
        endcase

        if (finish)
        begin
            tick_next = '0;
            sck_next  = 1'b0;
            if (!second_reg)
            begin
                held_next   = shift_reg;
                second_next = 1'b1;
                phase_next  = (settle_reg != '0) ? ST_SETTLE : ST_WAIT;
            end
            else
            begin
                phase_next = ST_IDLE;
                done       = 1'b1;
                reading_a  = held_reg;
                reading_b  = shift_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= ST_IDLE;
            tick_reg        <= '0;
            bit_reg         <= '0;
            pulse_reg       <= '0;
            shift_reg       <= '0;
            second_reg      <= 1'b0;
            held_reg        <= '0;
            sck_reg         <= 1'b0;
            stage_valid_reg <= 1'b0;
            stage_flags_reg <= '0;
            stage_a_reg     <= '0;
            stage_b_reg     <= '0;
        end
        else
        begin
            if (tick_ready)
            begin
                stage_valid_reg <= accept;
            end
            if (accept)
            begin
                phase_reg                 <= phase_next;
                tick_reg                  <= tick_next;
                bit_reg                   <= bit_next;
                pulse_reg                 <= pulse_next;
                shift_reg                 <= shift_next;
                second_reg                <= second_next;
                held_reg                  <= held_next;
                sck_reg                   <= sck_next;
                stage_flags_reg.sck_level <= sck_next;
                stage_flags_reg.busy_res  <= (phase_next != ST_IDLE);
                stage_flags_reg.done_res  <= done;
                stage_flags_reg.status    <= timed_out ? STATUS_TIMEOUT : STATUS_OK;
                stage_a_reg               <= reading_a;
                stage_b_reg               <= reading_b;
            end
        end
    end

    bsr_scale #(
        .DATA_BITS (DATA_BITS)
    ) u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage_valid  (stage_valid_reg),
        .stage_ready  (stage_ready),
        .stage_flags  (stage_flags_reg),
        .reading_a    (stage_a_reg),
        .reading_b    (stage_b_reg),
        .scale_a      (scale_a_reg),
        .scale_b      (scale_b_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

>>> src/bsr_scale.sv
// Output stage of the serial reader: Q16.16 scaling of both readings and
// the result register with its handshake. Depends on bsr_pkg.
module bsr_scale
    import bsr_pkg::*;
#(
    parameter int DATA_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  stage_valid,
    output logic                  stage_ready,
    input  flags_t                stage_flags,
    input  logic [DATA_BITS-1:0]  reading_a,
    input  logic [DATA_BITS-1:0]  reading_b,
    input  logic signed [31:0]    scale_a,
    input  logic signed [31:0]    scale_b,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result
);

    localparam int ProdW = DATA_BITS + 32;

    logic                   valid_reg;
    result_t                result_reg;
    result_t                result_next;
    logic                   advance;
    logic signed [ProdW-1:0] prod_a;
    logic signed [ProdW-1:0] prod_b;
    logic signed [63:0]     prod_a_ext;
    logic signed [63:0]     prod_b_ext;
    logic signed [63:0]     sext_a;
    logic signed [63:0]     sext_b;

    assign advance     = !valid_reg || result_ready;
    assign stage_ready = advance;

    assign prod_a     = ProdW'($signed(reading_a)) * ProdW'(scale_a);
    assign prod_b     = ProdW'($signed(reading_b)) * ProdW'(scale_b);
    assign prod_a_ext = 64'(prod_a);
    assign prod_b_ext = 64'(prod_b);
    assign sext_a     = 64'($signed(reading_a));
    assign sext_b     = 64'($signed(reading_b));

    always_comb
    begin
        result_next.sck_level = stage_flags.sck_level;
        result_next.busy_res  = stage_flags.busy_res;
        result_next.done_res  = stage_flags.done_res;
        result_next.status    = stage_flags.status;
        result_next.raw_a     = sext_a[RAW_W-1:0];
        result_next.raw_b     = sext_b[RAW_W-1:0];
        result_next.scaled_a  = prod_a_ext[SCALED_W+15:16];
        result_next.scaled_b  = prod_b_ext[SCALED_W+15:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= stage_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage_valid)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

>>> src/bsr_checker.sv
// Port-level checks for the serial reader, bound to the top level.
// Depends on bsr_pkg and bridge_adc_serial_reader.
module bsr_checker
    import bsr_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result request dropped while stalled");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.done_res |-> !result.busy_res)
        else $error("done reported while still busy");

    a_status_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status |-> result.done_res)
        else $error("timeout status without done");

    a_fields_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (!result.done_res || result.status) |->
            result.raw_a == '0 && result.raw_b == '0 &&
            result.scaled_a == '0 && result.scaled_b == '0)
        else $error("reading fields set without a good finish");

    a_clock_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.sck_level |-> result.busy_res)
        else $error("serial clock high while idle");

endmodule

bind bridge_adc_serial_reader bsr_checker u_bsr_checker (.*);

>>> bench/reader_check_pkg.sv
// Predictor and result tracker for the bridge converter serial reader bench.
// Depends on bsr_pkg for the request, result and register definitions.
`timescale 1ns / 100ps
package reader_check_pkg;
    import bsr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAIT,
        ST_HIGH,
        ST_LOW,
        ST_PULSE_HIGH,
        ST_PULSE_LOW,
        ST_SETTLE
    } seq_state_e;

    class reader_tracker;
        logic [7:0]               half_ticks;
        logic [TICK_W-1:0]        timeout_ticks;
        logic [TICK_W-1:0]        settle_ticks;
        logic [1:0]               pulses_a;
        logic [1:0]               pulses_b;
        logic signed [31:0]       scale_a;
        logic signed [31:0]       scale_b;
        seq_state_e               step;
        int unsigned              ticks;
        int unsigned              bits;
        logic [1:0]               pulses;
        logic [RAW_W-1:0]         shreg;
        logic [RAW_W-1:0]         first_reading;
        bit                       second;
        bit                       sck;
        result_t                  awaited[$];
        int unsigned              errors;

        function new();
            half_ticks    = RST_HALF_PERIOD;
            timeout_ticks = RST_READY_TIMEOUT;
            settle_ticks  = RST_SETTLE;
            pulses_a      = RST_PULSES_A;
            pulses_b      = RST_PULSES_B;
            scale_a       = RST_SCALE;
            scale_b       = RST_SCALE;
            step          = ST_IDLE;
            ticks         = 0;
            bits          = 0;
            pulses        = '0;
            shreg         = '0;
            first_reading = '0;
            second        = 1'b0;
            sck           = 1'b0;
            errors        = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_HALF_PERIOD:   half_ticks    = data[7:0];
                CFG_READY_TIMEOUT: timeout_ticks = data[TICK_W-1:0];
                CFG_SETTLE:        settle_ticks  = data[TICK_W-1:0];
                CFG_PULSES_A:      pulses_a      = data[1:0];
                CFG_PULSES_B:      pulses_b      = data[1:0];
                CFG_SCALE_A:       scale_a       = data;
                CFG_SCALE_B:       scale_b       = data;
                default: ;
            endcase
        endfunction

        function logic [SCALED_W-1:0] scaled(logic [RAW_W-1:0] raw, logic signed [31:0] k);
            longint p;
            p = longint'($signed(raw)) * longint'(k);
            return SCALED_W'(p >>> 16);
        endfunction

        function void take_tick(tick_t t);
            result_t     r;
            bit          done;
            bit          timed_out;
            bit          finish;
            logic [1:0]  target;
            int unsigned half;
            r         = '0;
            done      = 1'b0;
            timed_out = 1'b0;
            finish    = 1'b0;
            target    = second ? pulses_b : pulses_a;
            half      = (half_ticks == 0) ? 1 : half_ticks;
            case (step)
                ST_IDLE:
                begin
                    if (t.start_req)
                    begin
                        step   = ST_WAIT;
                        ticks  = 0;
                        second = 1'b0;
                    end
                    sck = 1'b0;
                end
                ST_WAIT:
                begin
                    if (!t.dout_level)
                    begin
                        step  = ST_HIGH;
                        ticks = 0;
                        bits  = 0;
                        shreg = '0;
                        sck   = 1'b1;
                    end
                    else
                    begin
                        ticks = (ticks + 1) & 32'hFFFFF;
                        if (ticks >= timeout_ticks)
                        begin
                            step      = ST_IDLE;
                            ticks     = 0;
                            done      = 1'b1;
                            timed_out = 1'b1;
                        end
                    end
                end
                ST_HIGH:
                begin
                    ticks++;
                    if (ticks >= half)
                    begin
                        shreg = {shreg[RAW_W-2:0], t.dout_level};
                        ticks = 0;
                        sck   = 1'b0;
                        step  = ST_LOW;
                    end
                end
                ST_LOW:
                begin
                    ticks++;
                    if (ticks >= half)
                    begin
                        ticks = 0;
                        bits++;
                        if (bits >= RAW_W)
                        begin
                            pulses = '0;
                            if (target == 0)
                                finish = 1'b1;
                            else
                            begin
                                step = ST_PULSE_HIGH;
                                sck  = 1'b1;
                            end
                        end
                        else
                        begin
                            step = ST_HIGH;
                            sck  = 1'b1;
                        end
                    end
                end
                ST_PULSE_HIGH:
                begin
                    ticks++;
                    if (ticks >= half)
                    begin
                        ticks = 0;
                        sck   = 1'b0;
                        step  = ST_PULSE_LOW;
                    end
                end
                ST_PULSE_LOW:
                begin
                    ticks++;
                    if (ticks >= half)
                    begin
                        ticks  = 0;
                        pulses = pulses + 2'd1;
                        if (pulses >= target)
                            finish = 1'b1;
                        else
                        begin
                            step = ST_PULSE_HIGH;
                            sck  = 1'b1;
                        end
                    end
                end
                ST_SETTLE:
                begin
                    ticks++;
                    if (ticks >= settle_ticks)
                    begin
                        ticks = 0;
                        step  = ST_WAIT;
                    end
                end
                default:
                begin
                    step = ST_IDLE;
                    sck  = 1'b0;
                end
            endcase

            if (finish)
            begin
                ticks = 0;
                sck   = 1'b0;
                if (!second)
                begin
                    first_reading = shreg;
                    second        = 1'b1;
                    step          = (settle_ticks != 0) ? ST_SETTLE : ST_WAIT;
                end
                else
                begin
                    step       = ST_IDLE;
                    done       = 1'b1;
                    r.raw_a    = first_reading;
                    r.raw_b    = shreg;
                    r.scaled_a = scaled(first_reading, scale_a);
                    r.scaled_b = scaled(shreg, scale_b);
                end
            end

            r.sck_level = sck;
            r.busy_res  = (step != ST_IDLE);
            r.done_res  = done;
            r.status    = timed_out ? STATUS_TIMEOUT : STATUS_OK;
            awaited.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void match_result(result_t got);
            result_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: result expected none actual %p", $time, got);
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare_field("sck_level", want.sck_level, got.sck_level);
            compare_field("busy_res", want.busy_res, got.busy_res);
            compare_field("done_res", want.done_res, got.done_res);
            compare_field("status", want.status, got.status);
            compare_field("raw_a", want.raw_a, got.raw_a);
            compare_field("raw_b", want.raw_b, got.raw_b);
            compare_field("scaled_a", want.scaled_a, got.scaled_a);
            compare_field("scaled_b", want.scaled_b, got.scaled_b);
        endfunction
    endclass

endpackage

>>> bench/tb_top.sv
// Top of the serial reader bench: clock, reset, request and result drivers,
// register set-up and the read sequences. Depends on bsr_pkg and reader_check_pkg.
`timescale 1ns / 100ps
module tb_top;
    import bsr_pkg::*;
    import reader_check_pkg::*;

    localparam int unsigned ITEM_TARGET = 1150;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   tick_valid   = 1'b0;
    logic                   tick_ready;
    tick_t                  tick         = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    result_t                result;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    bit                     steady       = 1'b0;
    int unsigned            sent         = 0;
    reader_tracker          tracker;

    bridge_adc_serial_reader u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .tick         (tick),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned idle_len();
        return steady ? 0 : $urandom_range(0, 4);
    endfunction

    task automatic drain();
        tick_valid <= 1'b0;
        @(posedge clk);
        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_tick(input logic dout, input logic start);
        int unsigned gap;
        tick_t       item;
        gap             = idle_len();
        item.dout_level = dout;
        item.start_req  = start;
        if ($urandom_range(0, 63) == 0)
            steady = ~steady;
        if ($urandom_range(0, 499) == 0)
            drain();
        if (gap != 0)
        begin
            tick_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick       <= item;
        do
            @(posedge clk);
        while (!tick_ready);
        tracker.take_tick(item);
        sent++;
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= index;
        cfg_data     <= data;
        @(posedge clk);
        tracker.set_reg(index, data);
    endtask

    task automatic setup(logic [31:0] half, logic [31:0] timeout, logic [31:0] settle,
                         logic [31:0] pa, logic [31:0] pb, logic [31:0] sa, logic [31:0] sb);
        drain();
        write_reg(CFG_HALF_PERIOD, half);
        write_reg(CFG_READY_TIMEOUT, timeout);
        write_reg(CFG_SETTLE, settle);
        write_reg(CFG_PULSES_A, pa);
        write_reg(CFG_PULSES_B, pb);
        write_reg(CFG_SCALE_A, sa);
        write_reg(CFG_SCALE_B, sb);
        cfg_write_en <= 1'b0;
    endtask

    task automatic wait_ready(int unsigned goal);
        while (tracker.step == ST_WAIT)
            send_tick(tracker.ticks < goal, 1'($urandom_range(0, 1)));
    endtask

    task automatic clock_word(logic [RAW_W-1:0] word);
        while (tracker.step inside {ST_HIGH, ST_LOW, ST_PULSE_HIGH, ST_PULSE_LOW})
            send_tick(tracker.step == ST_HIGH ? word[RAW_W - 1 - tracker.bits]
                                              : 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
    endtask

    task automatic run_read(int unsigned goal_a, logic [RAW_W-1:0] word_a,
                            int unsigned goal_b, logic [RAW_W-1:0] word_b);
        repeat ($urandom_range(0, 3))
            send_tick(1'($urandom_range(0, 1)), 1'b0);
        while (tracker.step == ST_IDLE)
            send_tick(1'($urandom_range(0, 1)), 1'b1);
        wait_ready(goal_a);
        if (tracker.step == ST_IDLE)
            return;
        clock_word(word_a);
        while (tracker.step == ST_SETTLE)
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        wait_ready(goal_b);
        if (tracker.step == ST_IDLE)
            return;
        clock_word(word_b);
    endtask

    function automatic int unsigned pick_goal();
        if (tracker.timeout_ticks < 64 && $urandom_range(0, 4) == 0)
            return tracker.timeout_ticks + 1;
        return $urandom_range(0, 6);
    endfunction

    function automatic logic [RAW_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 24'h800000;
            1:       return 24'h7FFFFF;
            2:       return '1;
            3:       return '0;
            default: return RAW_W'($urandom);
        endcase
    endfunction

    task automatic random_reads(int unsigned count);
        repeat (count)
            run_read(pick_goal(), pick_word(), pick_goal(), pick_word());
    endtask

    initial
    begin
        int unsigned spare;
        @(posedge rst_n);
        forever
        begin
            spare = idle_len();
            if (spare != 0)
            begin
                result_ready <= 1'b0;
                repeat (spare) @(posedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_valid);
            tracker.match_result(result);
        end
    end

    initial
    begin
        tracker = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);

        // zero half period, zero timeout, no extra pulses, no settle
        setup(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        run_read(1, '0, 0, '0);
        run_read(0, 24'h800000, 0, 24'h7FFFFF);

        setup(32'd1, 32'd1, 32'd0, 32'd3, 32'd3, 32'h7FFF_FFFF, 32'h8000_0000);
        run_read(0, 24'h7FFFFF, 0, 24'h800000);
        run_read(0, 24'hFFFFFF, 1, '0);
        run_read(0, 24'hFFFFFF, 0, 24'h000000);

        setup(32'd1, 32'd3, 32'd2, 32'd1, 32'd3, $urandom, $urandom);
        random_reads(3);

        setup(32'd2, 32'hFFFF_FFFF, 32'd0, 32'd2, 32'd2, 32'h0001_0000, 32'hFFFF_0000);
        random_reads(1);

        // upper bits of the half period dropped by the register width
        setup(32'hFFFF_FF02, 32'd5, 32'd7, 32'd3, 32'd1, $urandom, $urandom);
        run_read(2, pick_word(), 1, pick_word());

        // longest settle: only timeouts on the first channel, never reach it
        setup(32'd1, 32'd1, 32'hFFFF_FFFF, 32'd1, 32'd2, 32'd0, 32'd0);
        repeat (3) run_read(2, '0, 0, '0);

        while (sent < ITEM_TARGET)
        begin
            setup($urandom_range(0, 2), $urandom_range(0, 10), $urandom_range(0, 6),
                  $urandom_range(0, 3), $urandom_range(0, 3), $urandom, $urandom);
            random_reads(1);
        end

        tick_valid <= 1'b0;
        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (tracker.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
src/bsr_pkg.sv
src/bsr_scale.sv
src/bridge_adc_serial_reader.sv
src/bsr_checker.sv
bench/reader_check_pkg.sv
bench/tb_top.sv
